// ===== rtl/hsv_color_shade_macros.svh =====
// Assertion macros shared by the shading pipeline.
`ifndef HSV_COLOR_SHADE_MACROS_SVH
`define HSV_COLOR_SHADE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcs_pkg.sv =====
package hcs_pkg;

    // One incoming pixel word with its shade request.
    typedef struct packed {
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [2:0] shade_mode;
    } t_pix_in;

    // One shaded pixel word.
    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    // Shade mode codes.
    localparam logic [2:0] SHADE_NONE     = 3'd0;
    localparam logic [2:0] SHADE_DARKEST  = 3'd1;
    localparam logic [2:0] SHADE_DARKER   = 3'd2;
    localparam logic [2:0] SHADE_DARK     = 3'd3;
    localparam logic [2:0] SHADE_LIGHT    = 3'd4;
    localparam logic [2:0] SHADE_LIGHTER  = 3'd5;
    localparam logic [2:0] SHADE_LIGHTEST = 3'd6;

    // Color arithmetic constants.
    localparam logic [7:0] HUE_SEXTANT = 8'd43;
    localparam logic [7:0] HUE_BASE_G  = 8'd85;
    localparam logic [7:0] HUE_BASE_B  = 8'd171;
    localparam logic [7:0] CHAN_MAX    = 8'd255;
    localparam logic [7:0] REM_SCALE   = 8'd6;

    // Divider geometry: 8-bit quotients, quotient bits resolved per stage.
    localparam int DIV_DW  = 8;
    localparam int DIV_QW  = 8;
    localparam int DIV_BPS = 2;

    // Side data that rides alongside the dividers.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] mode;
        logic       active;
        logic       no_chroma;
        logic       hue_neg;
        logic [7:0] hue_base;
        logic [7:0] val;
    } t_side;

    // HSV word after shading, with region and scaled remainder.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       active;
        logic [7:0] val;
        logic [7:0] sat;
        logic [2:0] region;
        logic [7:0] rem;
    } t_hsv;

    // Partial products of the HSV to RGB step.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       active;
        logic       sat_zero;
        logic [7:0] val;
        logic [2:0] region;
        logic [7:0] p_val;
        logic [7:0] sat_rem;
        logic [7:0] sat_inv;
    } t_prod;

endpackage

// ===== rtl/hcs_div.sv =====
module hcs_div #(
    parameter int DW  = 8,
    parameter int QW  = 8,
    parameter int BPS = 2
) (
    input  logic                 i_clk,
    input  logic [QW/BPS-1:0]    i_en,
    input  logic [DW+QW-1:0]     i_num,
    input  logic [DW-1:0]        i_den,
    output logic [QW-1:0]        o_quo
);

    localparam int NS = QW / BPS;

    // The numerator's upper half must be below the divisor, so the quotient fits QW bits.
    logic [DW-1:0] r_rem [NS];
    logic [QW-1:0] r_low [NS];
    logic [QW-1:0] r_quo [NS];
    logic [DW-1:0] r_den [NS];

    logic [DW-1:0] s_rem [NS];
    logic [QW-1:0] s_low [NS];
    logic [QW-1:0] s_quo [NS];
    logic [DW-1:0] s_den [NS];

    logic [DW-1:0] n_rem [NS];
    logic [QW-1:0] n_low [NS];
    logic [QW-1:0] n_quo [NS];

    // Each stage starts from the previous stage's registers, the first from the inputs.
    always_comb begin
        s_rem[0] = i_num[DW+QW-1:QW];
        s_low[0] = i_num[QW-1:0];
        s_quo[0] = '0;
        s_den[0] = i_den;
        for (int k = 1; k < NS; k++) begin
            s_rem[k] = r_rem[k-1];
            s_low[k] = r_low[k-1];
            s_quo[k] = r_quo[k-1];
            s_den[k] = r_den[k-1];
        end
    end

    // Restoring division, BPS quotient bits per stage.
    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
        for (int k = 0; k < NS; k++) begin
            rem = s_rem[k];
            low = s_low[k];
            quo = s_quo[k];
            for (int b = 0; b < BPS; b++) begin
                trial = {rem, low[QW-1]};
                low   = {low[QW-2:0], 1'b0};
                if (trial >= {1'b0, s_den[k]}) begin
                    trial = trial - {1'b0, s_den[k]};
                    quo   = {quo[QW-2:0], 1'b1};
                end else begin
                    quo   = {quo[QW-2:0], 1'b0};
                end
                rem = trial[DW-1:0];
            end
            n_rem[k] = rem;
            n_low[k] = low;
            n_quo[k] = quo;
        end
    end

    // Stage registers advance under their own enables.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

// ===== rtl/hsv_color_shade.sv =====
// ARGB pixel shader through an 8-bit HSV round trip.
// Input channel: i_in_word carries alpha, red, green, blue and the shade mode; a word
// is taken at a rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_word carries the shaded pixel; it is taken where o_out_valid
// is high and i_out_stall is low. Every input word yields exactly one output word,
// in order.
// Mode 0 and the unused code 7 return the pixel as it came; modes 1 to 3 scale
// value, modes 4 to 6 scale saturation. Alpha always passes through.
// Depth: 4 + DIV_QW/DIV_BPS register stages, 8 with the default settings.
// Throughput: one word per clock while the receiver does not stall. The depth is set
// by the two pipelined dividers (saturation and hue), which resolve DIV_BPS quotient
// bits per stage.
// Each stage holds its word while the stage after it is full and stalled, so a
// bubble anywhere lets a new word in; o_in_stall is high only with every stage full
// and the receiver stalling.
// Reset (i_rst_n low at a clock edge) empties the pipeline; words in flight are dropped.
`include "hsv_color_shade_macros.svh"

module hsv_color_shade #(
    parameter int DIV_BPS = hcs_pkg::DIV_BPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  hcs_pkg::t_pix_in i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output hcs_pkg::t_pix_out o_out_word
);

    import hcs_pkg::*;

    localparam int NS   = DIV_QW / DIV_BPS;
    localparam int S_HSV = NS + 1;
    localparam int S_PRD = NS + 2;
    localparam int LAST = NS + 3;

    logic [LAST:0] r_vld;
    logic [LAST:0] n_vld;
    logic [LAST:0] stage_en;

    t_side         r_side [NS+1];
    t_side         n_side;
    logic [15:0]   r_sat_num, n_sat_num;
    logic [15:0]   r_hue_num, n_hue_num;
    logic [7:0]    r_delta, n_delta;
    logic [7:0]    sat_quo, hue_quo;
    t_hsv          r_hsv, n_hsv;
    t_prod         r_prod, n_prod;
    t_pix_out      r_out, n_out;

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        stage_en[LAST] = !r_vld[LAST] || !i_out_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign n_vld = {r_vld[LAST-1:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k <= LAST; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage one: max, min, sextant and the two division numerators.
    always_comb begin
        logic [7:0] r, g, b, mx, mn;
        logic [8:0] diff;
        logic [7:0] adiff;
        r = i_in_word.red_in;
        g = i_in_word.green_in;
        b = i_in_word.blue_in;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        if (mx == r) begin
            diff = {1'b0, g} - {1'b0, b};
            n_side.hue_base = '0;
        end else if (mx == g) begin
            diff = {1'b0, b} - {1'b0, r};
            n_side.hue_base = HUE_BASE_G;
        end else begin
            diff = {1'b0, r} - {1'b0, g};
            n_side.hue_base = HUE_BASE_B;
        end
        adiff = diff[8] ? 8'(-diff) : diff[7:0];
        n_delta            = mx - mn;
        n_side.alpha       = i_in_word.alpha_in;
        n_side.red         = r;
        n_side.green       = g;
        n_side.blue        = b;
        n_side.mode        = i_in_word.shade_mode;
        n_side.active      = (i_in_word.shade_mode >= SHADE_DARKEST)
                             && (i_in_word.shade_mode <= SHADE_LIGHTEST);
        n_side.no_chroma   = (mx == mn);
        n_side.hue_neg     = diff[8];
        n_side.val         = mx;
        n_sat_num          = {n_delta, 8'd0} - {8'd0, n_delta};
        n_hue_num          = 16'(adiff) * 16'(HUE_SEXTANT);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_side[0] <= n_side;
            r_sat_num <= n_sat_num;
            r_hue_num <= n_hue_num;
            r_delta   <= n_delta;
        end
        for (int k = 1; k <= NS; k++) begin
            if (stage_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Saturation: 255 * delta / max.
    hcs_div #(
        .DW  (DIV_DW),
        .QW  (DIV_QW),
        .BPS (DIV_BPS)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (stage_en[NS:1]),
        .i_num (r_sat_num),
        .i_den (r_side[0].val),
        .o_quo (sat_quo)
    );

    // Hue offset: 43 * |diff| / delta, sign applied afterwards.
    hcs_div #(
        .DW  (DIV_DW),
        .QW  (DIV_QW),
        .BPS (DIV_BPS)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (stage_en[NS:1]),
        .i_num (r_hue_num),
        .i_den (r_delta),
        .o_quo (hue_quo)
    );

    // Hue assembly, shading, and the hue region with its scaled remainder.
    always_comb begin
        t_side      sd;
        logic [7:0] hue, sat, val, base;
        logic [9:0] val3, sat3;
        logic [5:0] hoff;
        sd   = r_side[NS];
        hue  = sd.hue_neg ? (sd.hue_base - hue_quo) : (sd.hue_base + hue_quo);
        sat  = sat_quo;
        if (sd.no_chroma) begin
            hue = '0;
            sat = '0;
        end
        val  = sd.val;
        val3 = {2'b00, val} + {1'b0, val, 1'b0};
        sat3 = {2'b00, sat} + {1'b0, sat, 1'b0};
        case (sd.mode)
            SHADE_DARKEST: val = {2'b00, sd.val[7:2]};
            SHADE_DARKER:  val = {1'b0, sd.val[7:1]};
            SHADE_DARK:    val = val3[9:2];
            SHADE_LIGHT:   sat = sat3[9:2];
            SHADE_LIGHTER: sat = {1'b0, sat[7:1]};
            default:       sat = {2'b00, sat[7:2]};
        endcase
        if (hue >= 8'(5 * HUE_SEXTANT)) begin
            n_hsv.region = 3'd5;
            base         = 8'(5 * HUE_SEXTANT);
        end else if (hue >= 8'(4 * HUE_SEXTANT)) begin
            n_hsv.region = 3'd4;
            base         = 8'(4 * HUE_SEXTANT);
        end else if (hue >= 8'(3 * HUE_SEXTANT)) begin
            n_hsv.region = 3'd3;
            base         = 8'(3 * HUE_SEXTANT);
        end else if (hue >= 8'(2 * HUE_SEXTANT)) begin
            n_hsv.region = 3'd2;
            base         = 8'(2 * HUE_SEXTANT);
        end else if (hue >= HUE_SEXTANT) begin
            n_hsv.region = 3'd1;
            base         = HUE_SEXTANT;
        end else begin
            n_hsv.region = 3'd0;
            base         = '0;
        end
        hoff         = 6'(hue - base);
        n_hsv.rem    = 8'({2'b00, hoff} * REM_SCALE);
        n_hsv.alpha  = sd.alpha;
        n_hsv.red    = sd.red;
        n_hsv.green  = sd.green;
        n_hsv.blue   = sd.blue;
        n_hsv.active = sd.active;
        n_hsv.val    = val;
        n_hsv.sat    = sat;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[S_HSV]) begin
            r_hsv <= n_hsv;
        end
    end

    // First products: p, and saturation scaled by the remainder and its complement.
    always_comb begin
        logic [15:0] prod_p, prod_r, prod_i;
        prod_p = 16'(r_hsv.val) * 16'(CHAN_MAX - r_hsv.sat);
        prod_r = 16'(r_hsv.sat) * 16'(r_hsv.rem);
        prod_i = 16'(r_hsv.sat) * 16'(CHAN_MAX - r_hsv.rem);
        n_prod.alpha    = r_hsv.alpha;
        n_prod.red      = r_hsv.red;
        n_prod.green    = r_hsv.green;
        n_prod.blue     = r_hsv.blue;
        n_prod.active   = r_hsv.active;
        n_prod.sat_zero = (r_hsv.sat == '0);
        n_prod.val      = r_hsv.val;
        n_prod.region   = r_hsv.region;
        n_prod.p_val    = prod_p[15:8];
        n_prod.sat_rem  = prod_r[15:8];
        n_prod.sat_inv  = prod_i[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[S_PRD]) begin
            r_prod <= n_prod;
        end
    end

    // Second products q and t, then the channel selection by region.
    always_comb begin
        logic [15:0] prod_q, prod_t;
        logic [7:0]  q_val, t_val, v, p;
        prod_q = 16'(r_prod.val) * 16'(CHAN_MAX - r_prod.sat_rem);
        prod_t = 16'(r_prod.val) * 16'(CHAN_MAX - r_prod.sat_inv);
        q_val  = prod_q[15:8];
        t_val  = prod_t[15:8];
        v      = r_prod.val;
        p      = r_prod.p_val;
        n_out.alpha_out = r_prod.alpha;
        if (!r_prod.active) begin
            n_out.red_out   = r_prod.red;
            n_out.green_out = r_prod.green;
            n_out.blue_out  = r_prod.blue;
        end else if (r_prod.sat_zero) begin
            n_out.red_out   = v;
            n_out.green_out = v;
            n_out.blue_out  = v;
        end else begin
            case (r_prod.region)
                3'd0: begin
                    n_out.red_out = v;     n_out.green_out = t_val; n_out.blue_out = p;
                end
                3'd1: begin
                    n_out.red_out = q_val; n_out.green_out = v;     n_out.blue_out = p;
                end
                3'd2: begin
                    n_out.red_out = p;     n_out.green_out = v;     n_out.blue_out = t_val;
                end
                3'd3: begin
                    n_out.red_out = p;     n_out.green_out = q_val; n_out.blue_out = v;
                end
                3'd4: begin
                    n_out.red_out = t_val; n_out.green_out = p;     n_out.blue_out = v;
                end
                default: begin
                    n_out.red_out = v;     n_out.green_out = p;     n_out.blue_out = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_vld[LAST];
    assign o_in_stall  = !stage_en[0];

    // The input side stalls only when every stage holds a word.
    `HCS_ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_vld, "input stalled with a bubble in the pipeline")

    // Region and remainder stay within one hue sextant.
    `HCS_ASSERT_SAME(a_region_range, i_clk, i_rst_n, r_vld[S_HSV], (r_hsv.region <= 3'd5) && (r_hsv.rem <= 8'd252), "hue region or remainder out of range")

    // A stalled output word is not dropped by the pipeline.
    `HCS_ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "stalled output word lost")

endmodule

// ===== dv/hsv_color_shade_tb.sv =====
module hsv_color_shade_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcs_pkg::*;

    // The package stops at the lightest code; the last 3-bit code is unused.
    localparam logic [2:0] SHADE_UNUSED = 3'd7;

    localparam int RANDOM_WORDS = 1600;
    localparam int QUIET_FROM   = 1400;
    localparam int HOLD_AT      = 300;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Keeps the shaded pixels still owed by the block, oldest first.
    class shade_scoreboard;
        t_pix_out owed_pixels[$];
        int       errors;
        int       words_in;
        int       words_out;
        int       mode_hits[8];

        function new();
            errors    = 0;
            words_in  = 0;
            words_out = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        // Integer HSV round trip of one pixel word.
        function t_pix_out shade_pixel(t_pix_in w);
            int r, g, b, mx, mn, delta, hh, h, s, v;
            int region, rm, p, q, t;
            int sextant, base_g, base_b, full, rem_k;
            t_pix_out o;
            sextant = HUE_SEXTANT;
            base_g  = HUE_BASE_G;
            base_b  = HUE_BASE_B;
            full    = CHAN_MAX;
            rem_k   = REM_SCALE;
            r = w.red_in;
            g = w.green_in;
            b = w.blue_in;
            o.alpha_out = w.alpha_in;
            o.red_out   = w.red_in;
            o.green_out = w.green_in;
            o.blue_out  = w.blue_in;
            if (w.shade_mode != SHADE_NONE && w.shade_mode != SHADE_UNUSED) begin
                mx = (r > g) ? r : g;
                mx = (mx > b) ? mx : b;
                mn = (r < g) ? r : g;
                mn = (mn < b) ? mn : b;
                delta = mx - mn;
                h = 0;
                s = 0;
                v = mx;
                // A gray or black pixel has no hue and no saturation.
                if (delta != 0) begin
                    s = (full * delta) / mx;
                    if (mx == r) begin
                        hh = (sextant * (g - b)) / delta;
                    end else if (mx == g) begin
                        hh = base_g + (sextant * (b - r)) / delta;
                    end else begin
                        hh = base_b + (sextant * (r - g)) / delta;
                    end
                    h = hh & 255;
                end
                case (w.shade_mode)
                    SHADE_DARKEST: v = v >> 2;
                    SHADE_DARKER:  v = v >> 1;
                    SHADE_DARK:    v = (3 * v) >> 2;
                    SHADE_LIGHT:   s = (3 * s) >> 2;
                    SHADE_LIGHTER: s = s >> 1;
                    default:       s = s >> 2;
                endcase
                if (s == 0) begin
                    o.red_out   = v[7:0];
                    o.green_out = v[7:0];
                    o.blue_out  = v[7:0];
                end else begin
                    region = h / sextant;
                    rm = (h - region * sextant) * rem_k;
                    p = (v * (full - s)) >> 8;
                    q = (v * (full - ((s * rm) >> 8))) >> 8;
                    t = (v * (full - ((s * (full - rm)) >> 8))) >> 8;
                    case (region)
                        0: begin o.red_out = v[7:0]; o.green_out = t[7:0]; o.blue_out = p[7:0]; end
                        1: begin o.red_out = q[7:0]; o.green_out = v[7:0]; o.blue_out = p[7:0]; end
                        2: begin o.red_out = p[7:0]; o.green_out = v[7:0]; o.blue_out = t[7:0]; end
                        3: begin o.red_out = p[7:0]; o.green_out = q[7:0]; o.blue_out = v[7:0]; end
                        4: begin o.red_out = t[7:0]; o.green_out = p[7:0]; o.blue_out = v[7:0]; end
                        default: begin
                            o.red_out = v[7:0]; o.green_out = p[7:0]; o.blue_out = q[7:0];
                        end
                    endcase
                end
            end
            return o;
        endfunction

        function void note_input(t_pix_in w);
            owed_pixels.push_back(shade_pixel(w));
            mode_hits[w.shade_mode]++;
            words_in++;
        endfunction

        function void check_output(t_pix_out got);
            t_pix_out want;
            if (owed_pixels.size() == 0) begin
                $error("output word %h arrived with nothing owed", got);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            words_out++;
            if (got.alpha_out !== want.alpha_out) begin
                $error("alpha_out: expected %0d, got %0d", want.alpha_out, got.alpha_out);
                errors++;
            end
            if (got.red_out !== want.red_out) begin
                $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== want.green_out) begin
                $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== want.blue_out) begin
                $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                errors++;
            end
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_pix_in  i_in_word;
    logic     o_out_valid;
    logic     i_out_stall;
    t_pix_out o_out_word;

    shade_scoreboard sb = new();
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    bit hold_ran = 1'b0;
    int cycle_count = 0;

    hsv_color_shade dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offers one word, with an optional idle burst first, and returns after the
    // edge that takes it. Stall is sampled at the falling edge, where it is settled.
    task automatic send_word(input t_pix_in w);
        bit taken;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_input(w);
    endtask

    // Random pixel word, mostly of the shapes that stress the hue and
    // saturation paths: gray, fully saturated, dim and ties at the maximum.
    function automatic t_pix_in random_pixel();
        t_pix_in w;
        logic [7:0] lvl;
        w.alpha_in   = 8'($urandom);
        w.red_in     = 8'($urandom);
        w.green_in   = 8'($urandom);
        w.blue_in    = 8'($urandom);
        lvl          = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin w.green_in = lvl; w.blue_in = lvl; w.red_in = lvl; end
            1: begin w.red_in = 8'd255; w.blue_in = 8'd0; end
            2: begin w.green_in = 8'd255; w.red_in = 8'd0; end
            3: begin w.blue_in = 8'd255; w.green_in = 8'd0; end
            4: begin
                w.red_in   = 8'($urandom_range(0, 7));
                w.green_in = 8'($urandom_range(0, 7));
                w.blue_in  = 8'($urandom_range(0, 7));
            end
            5: begin w.green_in = w.red_in; end
            6: begin w.blue_in = w.green_in; end
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) begin
            w.shade_mode = ($urandom_range(0, 1) == 0) ? SHADE_NONE : SHADE_UNUSED;
        end else begin
            w.shade_mode = 3'($urandom_range(SHADE_DARKEST, SHADE_LIGHTEST));
        end
        return w;
    endfunction

    // Stimulus: reset, directed words, random words, drain.
    initial begin : stimulus
        logic [23:0] colors[12];
        t_pix_in w;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        // Black, white, gray, primaries, secondaries, a negative hue that
        // wraps, the top region, and ties at the maximum.
        colors = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
                   24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
                   24'hFF00FF, 24'hFF0028, 24'hC8C832, 24'h1E9696};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: every shade code over the special colors.
        for (int i = 0; i < 24; i++) begin
            w.alpha_in   = (i % 2 == 0) ? 8'h00 : 8'hFF;
            {w.red_in, w.green_in, w.blue_in} = colors[i % 12];
            w.shade_mode = 3'(i % 8);
            send_word(w);
        end

        // Random words; a long output hold-off early on, no idling at the end.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == HOLD_AT) hold_req = 1'b1;
            if (i == QUIET_FROM) quiet = 1'b1;
            send_word(random_pixel());
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Shaded %0d pixel words, %0d checked; codes none..unused hit %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.words_in, sb.words_out, sb.mode_hits[0], sb.mode_hits[1],
                 sb.mode_hits[2], sb.mode_hits[3], sb.mode_hits[4], sb.mode_hits[5],
                 sb.mode_hits[6], sb.mode_hits[7]);
        $display("Random idling on both sides, %0s long output hold-off, %0d mismatches.",
                 hold_ran ? "one" : "no", sb.errors);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none in the quiet part.
    initial begin : receiver
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                if (hold_req) begin
                    // Long hold-off so the pipeline fills and stalls its input.
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_req = 1'b0;
                    hold_ran = 1'b1;
                end else if ($urandom_range(0, 2) == 0) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Output monitor: a word shown at the falling edge with no stall is taken
    // at the next rising edge.
    initial begin : result_monitor
        forever begin
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                sb.check_output(o_out_word);
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hcs_pkg.sv
rtl/hcs_div.sv
rtl/hsv_color_shade.sv
dv/hsv_color_shade_tb.sv
